### rtl/stripe_crc_xor_parity_engine_unit_macros.svh
// Assertion macros for the stripe CRC and XOR parity engine.
`ifndef STRIPE_CRC_XOR_PARITY_ENGINE_UNIT_MACROS_SVH
`define STRIPE_CRC_XOR_PARITY_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scx implication check failed");

// Next-cycle implication, checked outside reset.
`define SCX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scx next-cycle check failed");

`endif

### rtl/scx_pkg.sv
// Shared types, constants and CRC-32C functions for the stripe parity engine.
package scx_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CRC_W = 32;
  localparam int unsigned POS_W = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CRC_W-1:0] CRC32C_POLY = 32'h82F6_3B78;

  localparam logic [CFG_IDX_W-1:0] CFG_CSUM_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED = 2'd2;

  localparam logic CSUM_ENABLE_RESET = 1'b1;
  localparam logic PARITY_ENABLE_RESET = 1'b1;
  localparam logic [CRC_W-1:0] CRC_SEED_RESET = 32'd1;

  localparam logic KIND_CSUM = 1'b0;
  localparam logic KIND_PARITY = 1'b1;

  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_AW = 3;
  localparam int unsigned OQ_CW = OQ_AW + 1;
  localparam int unsigned OQ_SW = OQ_CW + 1;

  typedef struct packed {
    logic               kind;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    logic               last;
  } scx_result_t;

  typedef struct packed {
    logic valid;
    logic first_word;
    logic first_stripe;
    logic stripe_end;
    logic last_stripe;
  } scx_stage_t;

  typedef logic [CRC_W+VALUE_W-1:0][CRC_W-1:0] crc_mat_t;

  // bit-serial reference form, evaluated at elaboration only
  function automatic logic [CRC_W-1:0] crc_serial(input logic [CRC_W-1:0] crc_in,
                                                  input logic [VALUE_W-1:0] word);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc_in;
    for (int b = 0; b < VALUE_W; b++) begin
      fb = c[0] ^ word[b];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC32C_POLY;
      end
    end
    return c;
  endfunction

  function automatic crc_mat_t crc_build();
    crc_mat_t         m;
    logic [CRC_W-1:0] c;
    logic [VALUE_W-1:0] d;
    for (int j = 0; j < CRC_W + VALUE_W; j++) begin
      c = (j < CRC_W) ? (CRC_W'(1) << j) : '0;
      d = (j >= CRC_W) ? (VALUE_W'(1) << (j - CRC_W)) : '0;
      m[j] = crc_serial(c, d);
    end
    return m;
  endfunction

  localparam crc_mat_t CRC_MAT = crc_build();

  // one quadword step as a flat XOR network over the state and data bits
  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc_in,
                                                input logic [VALUE_W-1:0] word);
    logic [CRC_W+VALUE_W-1:0] v;
    logic [CRC_W-1:0]         r;
    v = {word, crc_in};
    r = '0;
    for (int i = 0; i < CRC_W + VALUE_W; i++) begin
      if (v[i]) begin
        r = r ^ CRC_MAT[i];
      end
    end
    return r;
  endfunction

endpackage

### rtl/scx_crc.sv
// Running CRC-32C accumulator over the current stripe.
module scx_crc import scx_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  scx_stage_t       stage,
  input  logic [CRC_W-1:0] seed,
  input  logic [VALUE_W-1:0] word,
  output logic [CRC_W-1:0] crc
);

  logic [CRC_W-1:0] acc;
  logic [CRC_W-1:0] start;

  assign start = stage.first_word ? seed : acc;
  assign crc = crc_step(start, word);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= CRC_SEED_RESET;
    end else if (stage.valid) begin
      acc <= crc;
    end
  end

endmodule

### rtl/scx_parity.sv
// Parity stripe buffer: read at acceptance, XOR and write back in the next cycle.
module scx_parity import scx_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  input  scx_stage_t         stage,
  input  logic [AW-1:0]      addr,
  input  logic [VALUE_W-1:0] word,
  output logic [VALUE_W-1:0] parity
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata;
  logic               fw_valid;
  logic [AW-1:0]      fw_addr;
  logic [VALUE_W-1:0] fw_data;
  logic [VALUE_W-1:0] old;

  // last write may land on the same edge as the read of that entry
  assign old = (fw_valid && fw_addr == addr) ? fw_data : rdata;
  assign parity = stage.first_stripe ? word : (old ^ word);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (stage.valid) begin
      mem[addr] <= parity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (stage.valid) begin
      fw_valid <= 1'b1;
    end
    if (stage.valid) begin
      fw_addr <= addr;
      fw_data <= parity;
    end
  end

endmodule

### rtl/scx_outq.sv
// Result queue with two push ports and one pop port.
module scx_outq import scx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push0_en,
  input  scx_result_t push0,
  input  logic        push1_en,
  input  scx_result_t push1,
  output logic        out_valid,
  input  logic        out_stall,
  output scx_result_t head,
  output logic        full_stall
);

  scx_result_t      q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic [OQ_CW-1:0] count;
  logic [1:0]       npush;
  logic             pop;
  logic [OQ_SW-1:0] need;

  assign npush = {1'b0, push0_en} + {1'b0, push1_en};
  assign out_valid = (count != '0);
  assign pop = out_valid && !out_stall;
  assign head = q[rd_ptr];
  // room for this cycle's pushes plus a full pair from the next transaction
  assign need = OQ_SW'(count) + OQ_SW'(npush) + OQ_SW'(2);
  assign full_stall = (need > OQ_SW'(OQ_DEPTH));

  always_ff @(posedge clk) begin
    if (push0_en) begin
      q[wr_ptr] <= push0;
    end
    if (push1_en) begin
      q[wr_ptr + OQ_AW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(npush);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_AW'(1);
      end
      count <= count + OQ_CW'(npush) - OQ_CW'(pop);
    end
  end

endmodule

### rtl/stripe_crc_xor_parity_engine_unit.sv
// Top level of the stripe CRC-32C and XOR parity engine.
// Takes one 64-bit word per cycle while in_stall is low. The word is accepted, the parity buffer
// entry for its offset is read from a one-port-read, one-port-write memory,
// and in the next cycle the XOR and CRC-32C update are done, the entry is
// written back (with a bypass for back-to-back hits on the same entry) and
// up to two results enter an 8-entry result queue. in_stall rises only
// when the queue, after this cycle's pushes, could not take two more
// results; the output side drains one result per cycle while out_stall
// is low, so when both enables are set the last word of each block
// pushes two results into the queue (parity word plus checksum).
`include "stripe_crc_xor_parity_engine_unit_macros.svh"
module stripe_crc_xor_parity_engine_unit import scx_pkg::*; #(
  parameter int STRIPES = 8,
  parameter int STRIPE_WORDS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_W-1:0]    data_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  kind,
  output logic [POS_W-1:0]      position,
  output logic [VALUE_W-1:0]    value,
  output logic                  last
);

  localparam int WP_W = (STRIPE_WORDS > 1) ? $clog2(STRIPE_WORDS) : 1;
  localparam int SI_W = $clog2(STRIPES);
  localparam logic [WP_W-1:0] W_LAST = WP_W'(STRIPE_WORDS - 1);
  localparam logic [SI_W-1:0] S_LAST = SI_W'(STRIPES - 1);

  logic             csum_enable;
  logic             parity_enable;
  logic [CRC_W-1:0] crc_seed;

  logic [WP_W-1:0] w_cnt;
  logic [SI_W-1:0] s_cnt;
  logic            accept;

  scx_stage_t         s1;
  logic [VALUE_W-1:0] s1_word;
  logic [WP_W-1:0]    s1_w;
  logic [SI_W-1:0]    s1_s;

  logic [CRC_W-1:0]   crc;
  logic [VALUE_W-1:0] parity;

  logic        par_en;
  logic        cs_en;
  logic        block_end;
  scx_result_t par_res;
  scx_result_t cs_res;
  scx_result_t push0;
  scx_result_t head;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      csum_enable <= CSUM_ENABLE_RESET;
      parity_enable <= PARITY_ENABLE_RESET;
      crc_seed <= CRC_SEED_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CSUM_ENABLE:   csum_enable <= cfg_data[0];
        CFG_PARITY_ENABLE: parity_enable <= cfg_data[0];
        CFG_CRC_SEED:      crc_seed <= cfg_data[CRC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_cnt <= '0;
      s_cnt <= '0;
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= accept;
      if (accept) begin
        if (w_cnt == W_LAST) begin
          w_cnt <= '0;
          s_cnt <= (s_cnt == S_LAST) ? '0 : s_cnt + SI_W'(1);
        end else begin
          w_cnt <= w_cnt + WP_W'(1);
        end
      end
    end
    if (accept) begin
      s1.first_word <= (w_cnt == '0);
      s1.first_stripe <= (s_cnt == '0);
      s1.stripe_end <= (w_cnt == W_LAST);
      s1.last_stripe <= (s_cnt == S_LAST);
      s1_word <= data_word;
      s1_w <= w_cnt;
      s1_s <= s_cnt;
    end
  end

  scx_crc u_crc (
    .clk   (clk),
    .rst   (rst),
    .stage (s1),
    .seed  (crc_seed),
    .word  (s1_word),
    .crc   (crc)
  );

  scx_parity #(
    .DEPTH (STRIPE_WORDS),
    .AW    (WP_W)
  ) u_parity (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (w_cnt),
    .stage   (s1),
    .addr    (s1_w),
    .word    (s1_word),
    .parity  (parity)
  );

  assign par_en = s1.valid && s1.last_stripe && parity_enable;
  assign cs_en = s1.valid && s1.stripe_end && csum_enable;
  assign block_end = s1.stripe_end && s1.last_stripe;

  always_comb begin
    par_res.kind = KIND_PARITY;
    par_res.position = POS_W'(s1_w);
    par_res.value = parity;
    par_res.last = block_end && !cs_en;
    cs_res.kind = KIND_CSUM;
    cs_res.position = POS_W'(s1_s);
    cs_res.value = {{(VALUE_W - CRC_W){1'b0}}, crc};
    cs_res.last = block_end;
    push0 = par_en ? par_res : cs_res;
  end

  scx_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push0_en   (par_en || cs_en),
    .push0      (push0),
    .push1_en   (par_en && cs_en),
    .push1      (cs_res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head       (head),
    .full_stall (in_stall)
  );

  assign kind = head.kind;
  assign position = head.position;
  assign value = head.value;
  assign last = head.last;

  `SCX_ASSERT_NEXT(ap_accept_enters_stage, accept, s1.valid)
  `SCX_ASSERT_IMPL(ap_block_end_wraps, s1.valid && block_end, w_cnt == '0 && s_cnt == '0)
  `SCX_ASSERT_NEXT(ap_word_wrap, accept && w_cnt == W_LAST, w_cnt == '0)

endmodule

### test/stripe_crc_xor_parity_engine_unit_test.sv
// Testbench for the stripe CRC-32C and XOR parity engine: predicted results checked per transaction.
`timescale 1ns / 100ps
module stripe_crc_xor_parity_engine_unit_test;
  import scx_pkg::*;

  localparam int STRIPES = 8;
  localparam int STRIPE_WORDS = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [VALUE_W-1:0]    data_word;
  logic                  out_valid;
  logic                  out_stall;
  logic                  kind;
  logic [POS_W-1:0]      position;
  logic [VALUE_W-1:0]    value;
  logic                  last;

  stripe_crc_xor_parity_engine_unit #(
    .STRIPES(STRIPES),
    .STRIPE_WORDS(STRIPE_WORDS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_word(data_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .position(position),
    .value(value),
    .last(last)
  );

  // engine image
  bit                 csum_on = 1'b1;
  bit                 parity_on = 1'b1;
  logic [CRC_W-1:0]   seed_reg = CRC_SEED_RESET;
  logic [CRC_W-1:0]   crc_q = CRC_SEED_RESET;
  logic [VALUE_W-1:0] parity_mem [STRIPE_WORDS];
  int                 word_q = 0;
  int                 stripe_q = 0;

  scx_result_t pending_results[$];
  int  errors = 0;
  int  words_sent = 0;
  int  results_checked = 0;
  int  blocks_done = 0;
  int  reg_writes = 0;
  bit  in_gaps = 1'b1;
  bit  out_gaps = 1'b1;
  bit  hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [CRC_W-1:0] crc32c_word(input logic [CRC_W-1:0] c,
                                                   input logic [VALUE_W-1:0] d);
    logic [CRC_W-1:0] acc;
    logic             fb;
    acc = c;
    for (int i = 0; i < VALUE_W; i++) begin
      fb = acc[0] ^ d[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ CRC32C_POLY;
      end
    end
    return acc;
  endfunction

  task automatic absorb_word(input logic [VALUE_W-1:0] w);
    logic [CRC_W-1:0]   start_crc;
    logic [VALUE_W-1:0] p;
    scx_result_t        par_res;
    scx_result_t        crc_res;
    bit                 stripe_end;
    bit                 last_stripe;
    bit                 emit_par;
    bit                 emit_crc;
    start_crc = (word_q == 0) ? seed_reg : crc_q;
    crc_q = crc32c_word(start_crc, w);
    p = (stripe_q == 0) ? w : (parity_mem[word_q] ^ w);
    parity_mem[word_q] = p;
    stripe_end = (word_q == STRIPE_WORDS - 1);
    last_stripe = (stripe_q == STRIPES - 1);
    emit_par = last_stripe && parity_on;
    emit_crc = stripe_end && csum_on;
    par_res.kind = KIND_PARITY;
    par_res.position = POS_W'(word_q);
    par_res.value = p;
    par_res.last = stripe_end && last_stripe && !emit_crc;
    crc_res.kind = KIND_CSUM;
    crc_res.position = POS_W'(stripe_q);
    crc_res.value = {{(VALUE_W - CRC_W){1'b0}}, crc_q};
    crc_res.last = stripe_end && last_stripe;
    if (emit_par) begin
      pending_results.push_back(par_res);
    end
    if (emit_crc) begin
      pending_results.push_back(crc_res);
    end
    if (stripe_end) begin
      word_q = 0;
      if (last_stripe) begin
        stripe_q = 0;
        blocks_done++;
      end else begin
        stripe_q++;
      end
    end else begin
      word_q++;
    end
  endtask

  // result checker
  initial begin
    scx_result_t got;
    scx_result_t want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.kind = kind;
        got.position = position;
        got.value = value;
        got.last = last;
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d position %0d value %h last %0d",
                 got.kind, got.position, got.value, got.last);
          errors++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
          end
          if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            errors++;
          end
          if (got.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, got.value);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  // output stall generator
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = out_gaps ? $urandom_range(0, 6) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid && !hold_req);
      @(posedge clk);
    end
  end

  function automatic logic [VALUE_W-1:0] rand_word();
    logic [VALUE_W-1:0] w;
    case ($urandom_range(0, 15))
      0: w = '0;
      1: w = '1;
      2: w = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      3: w = ~(VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
      default: w = {$urandom(), $urandom()};
    endcase
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] enable_data(input bit on);
    logic [CFG_DATA_W-1:0] d;
    d = $urandom();
    d[0] = on;
    return d;
  endfunction

  task automatic send_word(input logic [VALUE_W-1:0] w);
    int gap;
    gap = in_gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_word <= w;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    absorb_word(w);
    words_sent++;
  endtask

  task automatic send_until(input int stripe_t, input int word_t);
    while (!(stripe_q == stripe_t && word_q == word_t)) begin
      send_word(rand_word());
    end
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_CSUM_ENABLE: csum_on = d[0];
      CFG_PARITY_ENABLE: parity_on = d[0];
      CFG_CRC_SEED: seed_reg = d;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic test_directed_extremes();
    send_word('0);
    send_word('1);
    send_word(64'h0000_0000_0000_0001);
    send_word(64'h8000_0000_0000_0000);
    send_word(64'h5555_5555_5555_5555);
    send_word(64'hAAAA_AAAA_AAAA_AAAA);
    send_word(64'h0000_0000_FFFF_FFFF);
    send_word(64'hFFFF_FFFF_0000_0000);
    send_word(64'h0123_4567_89AB_CDEF);
  endtask

  // seed written mid-stripe only applies from the next stripe start
  task automatic test_seed_midstripe();
    settle_idle();
    write_reg(CFG_CRC_SEED, 32'hFFFF_FFFF);
    send_until(2, 0);
    settle_idle();
    write_reg(CFG_CRC_SEED, 32'h0000_0000);
    send_until(3, 0);
  endtask

  // parity word then checksum with last on the final word
  task automatic test_default_block_end();
    send_until(STRIPES - 1, STRIPE_WORDS - 4);
    send_word('1);
    send_word('0);
    send_word('1);
    send_word(64'h8000_0000_0000_0001);
  endtask

  task automatic test_enable_switching();
    settle_idle();
    write_reg(CFG_CSUM_ENABLE, enable_data(1'b0));
    write_reg(CFG_CRC_SEED, $urandom());
    send_until(4, 0);
    settle_idle();
    write_reg(CFG_CSUM_ENABLE, enable_data(1'b1));
    write_reg(CFG_PARITY_ENABLE, enable_data(1'b0));
    send_until(STRIPES - 1, 0);
  endtask

  // long output hold while words keep coming through the last stripe
  task automatic test_output_backpressure();
    settle_idle();
    write_reg(CFG_PARITY_ENABLE, enable_data(1'b1));
    in_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (STRIPE_WORDS) send_word(rand_word());
    in_gaps = 1'b1;
    settle_idle();
  endtask

  task automatic test_random_phases();
    int n;
    while (!(blocks_done == 2 && stripe_q == STRIPES - 1 && word_q == STRIPE_WORDS - 1)) begin
      settle_idle();
      if ($urandom_range(0, 1)) write_reg(CFG_CSUM_ENABLE, enable_data($urandom_range(0, 3) != 0));
      if ($urandom_range(0, 1)) write_reg(CFG_PARITY_ENABLE, enable_data($urandom_range(0, 3) != 0));
      case ($urandom_range(0, 5))
        0: write_reg(CFG_CRC_SEED, 32'h0000_0000);
        1: write_reg(CFG_CRC_SEED, 32'hFFFF_FFFF);
        2, 3: write_reg(CFG_CRC_SEED, $urandom());
        default: ;
      endcase
      in_gaps = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      n = $urandom_range(16, 160);
      while (n > 0 &&
             !(blocks_done == 2 && stripe_q == STRIPES - 1 && word_q == STRIPE_WORDS - 1)) begin
        send_word(rand_word());
        n--;
      end
    end
    in_gaps = 1'b1;
    out_gaps = 1'b1;
  endtask

  // final word with both outputs off: no transaction, so no last flag
  task automatic test_both_off_block_end();
    settle_idle();
    write_reg(CFG_CSUM_ENABLE, enable_data(1'b0));
    write_reg(CFG_PARITY_ENABLE, enable_data(1'b0));
    write_reg(CFG_NONE, $urandom());
    send_word(rand_word());
    settle_idle();
    write_reg(CFG_CSUM_ENABLE, enable_data(1'b1));
    write_reg(CFG_PARITY_ENABLE, enable_data(1'b1));
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_word <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_CSUM_ENABLE;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_seed_midstripe();
    test_default_block_end();
    test_enable_switching();
    test_output_backpressure();
    test_random_phases();
    test_both_off_block_end();
    settle_idle();
    $display("Summary: %0d words in %0d blocks, %0d results checked", words_sent, blocks_done,
             results_checked);
    $display("Summary: %0d register writes, %0d mismatches", reg_writes, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
